>>> rtl/core/bdct_pkg.sv
// ----------------------------------------------------------------------------
// Battery discharge capacity tester package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
package bdct_pkg;

    localparam int CUTOFF_W   = 15;
    localparam int MA_W       = 16;
    localparam int MARGIN_W   = 13;
    localparam int PERIOD_W   = 16;
    localparam int MV_W       = 16;
    localparam int TIME_W     = 32;
    localparam int KNOB_W     = 18;
    localparam int CAP_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 88;
    localparam int M_DATA_W   = 88;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RST = CUTOFF_W'(3000);
    localparam logic [MA_W-1:0]     MAX_SP_RST = MA_W'(5000);
    localparam logic [MA_W-1:0]     STEP_RST   = MA_W'(10);
    localparam logic [MA_W-1:0]     MIN_RST    = MA_W'(100);
    localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(500);
    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF = 3'd0,
        CFG_MAX_SP = 3'd1,
        CFG_STEP   = 3'd2,
        CFG_MIN    = 3'd3,
        CFG_MARGIN = 3'd4,
        CFG_PERIOD = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CUTOFF_W-1:0] cutoff_mv;
        logic [MA_W-1:0]     max_setpoint_ma;
        logic [MA_W-1:0]     step_reduction_ma;
        logic [MA_W-1:0]     min_discharge_ma;
        logic [MARGIN_W-1:0] drop_margin_mv;
        logic [PERIOD_W-1:0] update_period_ms;
    } t_cfg;

    typedef struct packed {
        logic                     restart;
        logic [TIME_W-1:0]        now_ms;
        logic [MV_W-1:0]          voltage_mv;
        logic [MA_W-1:0]          current_ma;
        logic                     load_enabled;
        logic signed [KNOB_W-1:0] knob_ma;
    } t_sample;

    typedef struct packed {
        logic [CAP_W-1:0]  capacity_accum;
        logic              running_flag;
        logic [TIME_W-1:0] last_update_time;
        logic [MA_W-1:0]   captured_current;
    } t_state;

    typedef struct packed {
        logic [MA_W-1:0]  setpoint_ma;
        logic [CAP_W-1:0] capacity_units;
        logic             timer_running;
        logic             test_done;
        logic [MA_W-1:0]  final_current_ma;
    } t_result;

endpackage

>>> rtl/core/battery_discharge_capacity_tester.sv
// ----------------------------------------------------------------------------
// Battery discharge capacity tester
// Electronic-load discharge test: capacity count, setpoint control, end check.
// ----------------------------------------------------------------------------
// Each sample beat produces exactly one result beat; an accepted sample
// passes through the input register and then the result register. A new
// sample is taken every cycle while the result slot is empty or draining;
// the test state (capacity, running flag, last update time, captured
// current) is written when a sample moves from the input register to the
// result register, so the next sample always sees it. Throughput is one
// sample per cycle, limited only by output backpressure. Configuration
// registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata and should
// change only while no sample is in flight. Capacity counts 1/7200 mAh units and
// saturates at its 48-bit maximum.
// ----------------------------------------------------------------------------
module battery_discharge_capacity_tester
    import bdct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // sample stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // restart[0], now_ms[32:1], voltage_mv[48:33], current_ma[64:49],
    // load_enabled[65], knob_ma[83:66], zero[87:84]
    input  logic [S_DATA_W-1:0]   i_s_tdata,
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // setpoint_ma[15:0], capacity_units[63:16], timer_running[64],
    // test_done[65], final_current_ma[81:66], zero[87:82]
    output logic [M_DATA_W-1:0]   o_m_tdata
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_sample r_smp;
    logic    r_in_vld;
    t_result r_res;
    t_result n_res;
    logic    r_out_vld;
    logic    advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cutoff_mv         <= CUTOFF_RST;
            r_cfg.max_setpoint_ma   <= MAX_SP_RST;
            r_cfg.step_reduction_ma <= STEP_RST;
            r_cfg.min_discharge_ma  <= MIN_RST;
            r_cfg.drop_margin_mv    <= MARGIN_RST;
            r_cfg.update_period_ms  <= PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CUTOFF: r_cfg.cutoff_mv         <= i_cfg_wdata[CUTOFF_W-1:0];
                CFG_MAX_SP: r_cfg.max_setpoint_ma   <= i_cfg_wdata[MA_W-1:0];
                CFG_STEP:   r_cfg.step_reduction_ma <= i_cfg_wdata[MA_W-1:0];
                CFG_MIN:    r_cfg.min_discharge_ma  <= i_cfg_wdata[MA_W-1:0];
                CFG_MARGIN: r_cfg.drop_margin_mv    <= i_cfg_wdata[MARGIN_W-1:0];
                CFG_PERIOD: r_cfg.update_period_ms  <= i_cfg_wdata[PERIOD_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Advance the input register into the result register whenever the
    // result slot is empty or is being drained this cycle.
    assign advance    = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    // Unpack the sample beat; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_smp.restart      <= i_s_tdata[0];
            r_smp.now_ms       <= i_s_tdata[32:1];
            r_smp.voltage_mv   <= i_s_tdata[48:33];
            r_smp.current_ma   <= i_s_tdata[64:49];
            r_smp.load_enabled <= i_s_tdata[65];
            r_smp.knob_ma      <= i_s_tdata[83:66];
        end
    end

    bdct_step u_step (
        .i_smp   (r_smp),
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .o_res   (n_res),
        .o_state (n_state)
    );

    // Test state commits together with the result it produced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'd0, r_res.final_current_ma, r_res.test_done,
                         r_res.timer_running, r_res.capacity_units, r_res.setpoint_ma};

endmodule

>>> rtl/core/bdct_step.sv
// ----------------------------------------------------------------------------
// Battery discharge capacity tester sample datapath
// Computes one result and the next test state from one registered sample.
// ----------------------------------------------------------------------------
module bdct_step
    import bdct_pkg::*;
(
    input  t_sample i_smp,
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    output t_result o_res,
    output t_state  o_state
);

    logic              restart_run;
    logic [CAP_W-1:0]  cap_base;
    logic [MA_W-1:0]   cap_cur;
    logic              run_mid;
    logic              above_cut;
    logic              at_or_below_cut;
    logic [TIME_W-1:0] elapsed;
    logic              do_update;
    logic [CAP_W:0]    cap_sum;
    logic [CAP_W-1:0]  cap_next;
    logic [MA_W-1:0]   sp_clamp;
    logic [MA_W:0]     sp_diff;
    logic [MA_W-1:0]   sp_step;
    logic [MA_W:0]     end_sum;
    logic              end_hit;
    logic [MA_W-1:0]   sp_final;

    always_comb begin
        restart_run = i_smp.restart;
        cap_base    = restart_run ? '0 : i_state.capacity_accum;
        cap_cur     = restart_run ? '0 : i_state.captured_current;

        // Running flag follows the load while the battery is at or above cutoff.
        above_cut       = i_smp.voltage_mv >= MV_W'(i_cfg.cutoff_mv);
        at_or_below_cut = i_smp.voltage_mv <= MV_W'(i_cfg.cutoff_mv);
        if (above_cut) begin
            run_mid = i_smp.load_enabled;
        end else begin
            run_mid = restart_run ? 1'b0 : i_state.running_flag;
        end

        // Wrapping elapsed time against the update period.
        elapsed   = i_smp.now_ms - i_state.last_update_time;
        do_update = elapsed >= TIME_W'(i_cfg.update_period_ms);

        cap_sum = {1'b0, cap_base} + (CAP_W+1)'(i_smp.current_ma);
        if (do_update && run_mid) begin
            cap_next = cap_sum[CAP_W] ? '1 : cap_sum[CAP_W-1:0];
        end else begin
            cap_next = cap_base;
        end

        // Clamp the signed knob into [0, max].
        priority if (i_smp.knob_ma[KNOB_W-1]) begin
            sp_clamp = '0;
        end else if (i_smp.knob_ma[KNOB_W-2:0] > (KNOB_W-1)'(i_cfg.max_setpoint_ma)) begin
            sp_clamp = i_cfg.max_setpoint_ma;
        end else begin
            sp_clamp = i_smp.knob_ma[MA_W-1:0];
        end

        // Step down with a floor, no wrap on borrow.
        sp_diff = {1'b0, sp_clamp} - {1'b0, i_cfg.step_reduction_ma};
        if (sp_diff[MA_W] || (sp_diff[MA_W-1:0] < i_cfg.min_discharge_ma)) begin
            sp_step = i_cfg.min_discharge_ma;
        end else begin
            sp_step = sp_diff[MA_W-1:0];
        end

        // End of test with the load on: voltage + margin <= cutoff (never when margin exceeds cutoff).
        end_sum = {1'b0, i_smp.voltage_mv} + (MA_W+1)'(i_cfg.drop_margin_mv);
        end_hit = i_smp.load_enabled && (end_sum <= (MA_W+1)'(i_cfg.cutoff_mv));

        priority if (end_hit) begin
            sp_final = '0;
        end else if (i_smp.load_enabled && at_or_below_cut) begin
            sp_final = sp_step;
        end else begin
            sp_final = sp_clamp;
        end

        o_state.capacity_accum   = cap_next;
        o_state.running_flag     = run_mid && !end_hit;
        o_state.last_update_time = do_update ? i_smp.now_ms : i_state.last_update_time;
        o_state.captured_current = end_hit ? i_smp.current_ma : cap_cur;

        o_res.setpoint_ma      = sp_final;
        o_res.capacity_units   = cap_next;
        o_res.timer_running    = o_state.running_flag;
        o_res.test_done        = end_hit;
        o_res.final_current_ma = o_state.captured_current;
    end

endmodule

>>> dv/tb_battery_discharge_capacity_tester.sv
// ----------------------------------------------------------------------------
// Battery discharge capacity tester testbench
// Streams sample beats into the tester and scores every result beat against
// an in-bench model of the discharge test. The run covers directed corners,
// register extremes and randomized discharge runs, with random gaps on the
// sample side and random backpressure on the result side.
// ----------------------------------------------------------------------------
module tb_battery_discharge_capacity_tester;
    import bdct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 200000;  // cycles before the watchdog gives up
    localparam int RANDOM_ITEMS = 180;

    // DUT ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    // restart[0], now_ms[32:1], voltage_mv[48:33], current_ma[64:49],
    // load_enabled[65], knob_ma[83:66], zero[87:84]
    logic [S_DATA_W-1:0]   i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // setpoint_ma[15:0], capacity_units[63:16], timer_running[64],
    // test_done[65], final_current_ma[81:66], zero[87:82]
    logic [M_DATA_W-1:0]   o_m_tdata;

    // Model of the tester: register copy and test state
    t_cfg              cfg_now;
    logic [CAP_W-1:0]  cap_total;
    logic              run_flag;
    logic [TIME_W-1:0] last_tick_ms;
    logic [MA_W-1:0]   end_current;

    // Results predicted for accepted samples, oldest first
    t_result pending_results[$];

    int          mismatch_count;
    int          samples_sent;
    int unsigned cycle_count;
    bit          gapless;        // sample side sends back to back
    bit          sink_steady;    // result side never stalls
    logic [TIME_W-1:0] sim_ms;   // running millisecond clock for stimulus

    battery_discharge_capacity_tester u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the pipeline hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side backpressure: drop ready about 30% of cycles unless steady
    always @(posedge i_clk) begin
        if (sink_steady) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= 30);
        end
    end

    // ------------------------------------------------------------------------
    // Model: advance the test state by one sample and return its result.
    // ------------------------------------------------------------------------
    function automatic t_result discharge_step(input t_sample s);
        t_result           r;
        logic [TIME_W-1:0] elapsed;
        logic [CAP_W:0]    sum;
        longint            sp;
        longint            end_mv;
        r = '0;
        // Restart clears the test but keeps the update time base
        if (s.restart) begin
            cap_total   = '0;
            run_flag    = 1'b0;
            end_current = '0;
        end
        if (s.load_enabled && s.voltage_mv >= cfg_now.cutoff_mv) run_flag = 1'b1;
        // Load off below the cutoff leaves the flag alone
        if (!s.load_enabled && s.voltage_mv >= cfg_now.cutoff_mv) run_flag = 1'b0;

        // Elapsed time wraps modulo 2^32; a zero period updates every sample
        elapsed = s.now_ms - last_tick_ms;
        if (elapsed >= TIME_W'(cfg_now.update_period_ms)) begin
            last_tick_ms = s.now_ms;
            if (run_flag) begin
                sum = {1'b0, cap_total} + (CAP_W+1)'(s.current_ma);
                cap_total = sum[CAP_W] ? '1 : sum[CAP_W-1:0];
            end
        end

        sp = longint'($signed(s.knob_ma));
        if (sp < 0) sp = 0;
        if (sp > longint'(cfg_now.max_setpoint_ma)) sp = longint'(cfg_now.max_setpoint_ma);

        if (s.load_enabled) begin
            // Step down without wrap, then lift to the floor
            if (s.voltage_mv <= cfg_now.cutoff_mv) begin
                sp = sp - longint'(cfg_now.step_reduction_ma);
                if (sp < longint'(cfg_now.min_discharge_ma)) begin
                    sp = longint'(cfg_now.min_discharge_ma);
                end
            end
            // A margin above the cutoff gives a negative end voltage: never ends
            end_mv = longint'(cfg_now.cutoff_mv) - longint'(cfg_now.drop_margin_mv);
            if (longint'(s.voltage_mv) <= end_mv) begin
                end_current = s.current_ma;
                sp = 0;
                run_flag = 1'b0;
                r.test_done = 1'b1;
            end
        end

        r.setpoint_ma      = sp[MA_W-1:0];
        r.capacity_units   = cap_total;
        r.timer_running    = run_flag;
        r.final_current_ma = end_current;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking. Sample at the falling edge: a beat seen with valid and
    // ready high here is taken at the next rising edge.
    // ------------------------------------------------------------------------
    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %h",
                         $time, o_m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("setpoint_ma", 64'(want.setpoint_ma), 64'(o_m_tdata[15:0]));
                check_field("capacity_units", 64'(want.capacity_units),
                            64'(o_m_tdata[63:16]));
                check_field("timer_running", 64'(want.timer_running), 64'(o_m_tdata[64]));
                check_field("test_done", 64'(want.test_done), 64'(o_m_tdata[65]));
                check_field("final_current_ma", 64'(want.final_current_ma),
                            64'(o_m_tdata[81:66]));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Send one sample beat. Called at a rising edge; returns at the edge that
    // took the beat, leaving valid high so the next beat can follow directly.
    task automatic send_sample(input t_sample s);
        bit taken;
        if (!gapless && $urandom_range(0, 99) < 30) begin
            i_s_tvalid <= 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(4, 12)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_DATA_W-84){1'b0}}, s.knob_ma, s.load_enabled, s.current_ma,
                       s.voltage_mv, s.now_ms, s.restart};
        do begin
            @(negedge i_clk);
            taken = o_s_tready;
            @(posedge i_clk);
        end while (!taken);
        pending_results.push_back(discharge_step(s));
        samples_sent++;
    endtask

    // Drop valid and hold until every result is back, plus the pipeline depth
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // Write all six registers back to back; only call while idle
    task automatic load_settings(input t_cfg c);
        put_reg(CFG_CUTOFF, CFG_DATA_W'(c.cutoff_mv));
        put_reg(CFG_MAX_SP, c.max_setpoint_ma);
        put_reg(CFG_STEP,   c.step_reduction_ma);
        put_reg(CFG_MIN,    c.min_discharge_ma);
        put_reg(CFG_MARGIN, CFG_DATA_W'(c.drop_margin_mv));
        put_reg(CFG_PERIOD, c.update_period_ms);
        i_cfg_we <= 1'b0;
        cfg_now = c;
    endtask

    function automatic t_sample mk_sample(input bit restart, input logic [31:0] now_ms,
                                          input int volt, input int curr,
                                          input bit load, input int knob);
        t_sample s;
        s.restart      = restart;
        s.now_ms       = now_ms;
        s.voltage_mv   = volt[MV_W-1:0];
        s.current_ma   = curr[MA_W-1:0];
        s.load_enabled = load;
        s.knob_ma      = knob[KNOB_W-1:0];
        return s;
    endfunction

    function automatic t_cfg random_settings();
        t_cfg c;
        c.cutoff_mv         = CUTOFF_W'($urandom_range(100, 25000));
        c.max_setpoint_ma   = ($urandom_range(0, 1) != 0) ? MA_W'($urandom_range(0, 10000))
                                                          : MA_W'($urandom);
        c.step_reduction_ma = ($urandom_range(0, 1) != 0) ? MA_W'($urandom_range(0, 200))
                                                          : MA_W'($urandom);
        c.min_discharge_ma  = ($urandom_range(0, 1) != 0) ? MA_W'($urandom_range(0, 500))
                                                          : MA_W'($urandom);
        c.drop_margin_mv    = MARGIN_W'($urandom_range(0, 5000));
        c.update_period_ms  = ($urandom_range(0, 3) != 0) ? PERIOD_W'($urandom_range(1, 1000))
                                                          : PERIOD_W'($urandom_range(1, 65535));
        return c;
    endfunction

    // Any sample at all: random fields, voltage often near the cutoff band
    function automatic t_sample stray_sample();
        t_sample s;
        int      v;
        s.restart      = ($urandom_range(0, 7) == 0);
        s.now_ms       = ($urandom_range(0, 1) != 0) ? TIME_W'($urandom)
                                                     : sim_ms + $urandom_range(0, 2000);
        v = int'(cfg_now.cutoff_mv) + $urandom_range(0, 6000) - 5500;
        if (v < 0) v = 0;
        s.voltage_mv   = ($urandom_range(0, 1) != 0) ? MV_W'($urandom) : MV_W'(v);
        s.current_ma   = MA_W'($urandom);
        s.load_enabled = 1'($urandom_range(0, 1));
        s.knob_ma      = KNOB_W'($urandom);
        return s;
    endfunction

    // One well-formed discharge: restart, load mostly on, time moving forward and the
    // voltage sagging from the cutoff or above until the end voltage or 40 samples
    task automatic run_discharge();
        t_sample s;
        int      v;
        int      knob;
        int      top;
        longint  end_mv;
        end_mv = longint'(cfg_now.cutoff_mv) - longint'(cfg_now.drop_margin_mv);
        v = int'(cfg_now.cutoff_mv) + $urandom_range(0, 1500);
        for (int n = 0; n < 40; n++) begin
            sim_ms = sim_ms + $urandom_range(0, 2 * int'(cfg_now.update_period_ms) + 2);
            top = int'(cfg_now.max_setpoint_ma) + 300;
            if (top > 131071) top = 131071;
            knob = ($urandom_range(0, 9) == 0) ? int'($urandom) : $urandom_range(0, top + 300) - 300;
            s.restart      = (n == 0);
            s.now_ms       = sim_ms;
            s.voltage_mv   = MV_W'(v);
            s.current_ma   = ($urandom_range(0, 3) != 0) ? MA_W'($urandom_range(0, 6000))
                                                         : MA_W'($urandom);
            s.load_enabled = ($urandom_range(0, 9) != 0);
            s.knob_ma      = knob[KNOB_W-1:0];
            send_sample(s);
            // Stop once this beat ended the test
            if (s.load_enabled && longint'(v) <= end_mv) break;
            v = v - $urandom_range(0, int'(cfg_now.drop_margin_mv) / 3 + 80);
            if (v < 0) v = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: clamp limits, flag rules, update period, step-down,
    // floor, end of test, restart and time wrap
    task automatic test_directed_corners();
        send_sample(mk_sample(1, 32'd0,    4000,  1000,  1, 2000));    // start, no update yet
        send_sample(mk_sample(0, 32'd500,  4000,  1000,  1, 131071));  // update, clamp high
        send_sample(mk_sample(0, 32'd999,  4000,  65535, 1, -131072)); // short of period, clamp 0
        send_sample(mk_sample(0, 32'd1000, 65535, 65535, 1, -1));      // full-scale add
        send_sample(mk_sample(0, 32'd1200, 5000,  500,   0, 3000));    // load off clears flag
        send_sample(mk_sample(0, 32'd1500, 5000,  500,   0, 0));       // update with flag low
        send_sample(mk_sample(0, 32'd1600, 3000,  700,   1, 4000));    // at cutoff: set, step
        send_sample(mk_sample(0, 32'd2000, 3000,  700,   1, 50));      // step below floor
        send_sample(mk_sample(0, 32'd2100, 2000,  700,   0, 5000));    // load off below cutoff
        send_sample(mk_sample(0, 32'd2200, 2999,  800,   1, 0));       // floor from zero knob
        send_sample(mk_sample(0, 32'd2300, 2501,  800,   1, 2000));    // just above end voltage
        send_sample(mk_sample(0, 32'd2400, 2500,  900,   1, 2000));    // exactly at end voltage
        send_sample(mk_sample(0, 32'd2500, 0,     65535, 1, 131071));  // deep end, max current
        send_sample(mk_sample(0, 32'd2600, 0,     0,     0, 131071));  // load off holds capture
        send_sample(mk_sample(1, 32'd2700, 4000,  1234,  1, 1000));    // restart keeps time base
        send_sample(mk_sample(0, 32'hFFFF_FF00, 4000, 100, 1, 1000));  // large jump
        send_sample(mk_sample(0, 32'h0000_0010, 4000, 100, 1, 1000));  // wrap, short of period
        send_sample(mk_sample(0, 32'h0000_0200, 4000, 100, 1, 1000));  // wrap, period reached
        send_sample(mk_sample(1, 32'hFFFF_FFFF, 32768, 1, 1, 131071)); // high bits, restart
        wait_idle();
    endtask

    // Register extremes, a margin above the cutoff, and a zero update period
    task automatic test_register_extremes();
        t_cfg corners[5];
        corners[0] = '{cutoff_mv: 100, max_setpoint_ma: 0, step_reduction_ma: 0,
                       min_discharge_ma: 0, drop_margin_mv: 0, update_period_ms: 1};
        corners[1] = '{cutoff_mv: 25000, max_setpoint_ma: 65535, step_reduction_ma: 65535,
                       min_discharge_ma: 65535, drop_margin_mv: 5000, update_period_ms: 65535};
        corners[2] = '{cutoff_mv: 100, max_setpoint_ma: 65535, step_reduction_ma: 1,
                       min_discharge_ma: 65535, drop_margin_mv: 5000, update_period_ms: 0};
        corners[3] = '{cutoff_mv: 25000, max_setpoint_ma: 1000, step_reduction_ma: 65535,
                       min_discharge_ma: 0, drop_margin_mv: 0, update_period_ms: 0};
        corners[4] = '{cutoff_mv: 12345, max_setpoint_ma: 21845, step_reduction_ma: 43690,
                       min_discharge_ma: 300, drop_margin_mv: 2730, update_period_ms: 2};
        foreach (corners[k]) begin
            load_settings(corners[k]);
            run_discharge();
            repeat (4) send_sample(stray_sample());
            run_discharge();
            wait_idle();
        end
    endtask

    // Mostly well-formed discharges with random content, some stray beats;
    // new settings every hundred or so beats, first stretch without gaps
    task automatic test_random_discharge();
        int first;
        int next_cfg;
        first    = samples_sent;
        next_cfg = 0;
        sim_ms   = ($urandom_range(0, 1) != 0) ? TIME_W'($urandom) : 32'hFFFF_0000;
        gapless     = 1'b1;
        sink_steady = 1'b1;
        while (samples_sent - first < RANDOM_ITEMS) begin
            if (samples_sent - first >= 60) begin
                gapless     = 1'b0;
                sink_steady = 1'b0;
            end
            if (samples_sent - first >= next_cfg) begin
                wait_idle();
                load_settings(random_settings());
                next_cfg = samples_sent - first + 100;
            end
            if ($urandom_range(0, 9) < 8) begin
                run_discharge();
            end else begin
                repeat ($urandom_range(1, 3)) send_sample(stray_sample());
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_CUTOFF;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_m_tready  <= 1'b0;
        cycle_count    = 0;
        mismatch_count = 0;
        samples_sent   = 0;
        gapless        = 1'b0;
        sink_steady    = 1'b0;
        sim_ms         = '0;
        // Model starts from the reset register values and a cleared test
        cfg_now = '{cutoff_mv: CUTOFF_RST, max_setpoint_ma: MAX_SP_RST,
                    step_reduction_ma: STEP_RST, min_discharge_ma: MIN_RST,
                    drop_margin_mv: MARGIN_RST, update_period_ms: PERIOD_RST};
        cap_total    = '0;
        run_flag     = 1'b0;
        last_tick_ms = '0;
        end_current  = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_register_extremes();
        test_random_discharge();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bdct_pkg.sv
rtl/core/bdct_step.sv
rtl/core/battery_discharge_capacity_tester.sv
dv/tb_battery_discharge_capacity_tester.sv
